### sv/tlsa_pkg.sv
// Package for the timed lowest-slot allocator.
// Holds the fixed field widths and beat layouts; no dependencies.
package tlsa_pkg;

	// Widths of the request and result fields as they travel on the streams.
	localparam int unsigned TIME_FIELD_W = 32;
	localparam int unsigned SLOT_FIELD_W = 5;

	// Stream payload widths, padded to whole bytes.
	localparam int unsigned S_TDATA_W = 2 * TIME_FIELD_W;
	localparam int unsigned M_TDATA_W = ((SLOT_FIELD_W + 7) / 8) * 8;

	// Bit positions of the request fields in the slave-side tdata.
	localparam int unsigned ARRIVAL_LSB = 0;
	localparam int unsigned LEAVE_LSB   = TIME_FIELD_W;

	typedef logic [TIME_FIELD_W-1:0] time_field_t;
	typedef logic [SLOT_FIELD_W-1:0] slot_field_t;

endpackage

### sv/tlsa_slot_bank.sv
// Slot bank of the timed lowest-slot allocator: busy flags, stored leave
// times and the per-slot release compares. Uses no package items.
module tlsa_slot_bank #(
	parameter int unsigned NUM_SLOTS = 32,
	parameter int unsigned TIME_BITS = 32,
	parameter int unsigned IDX_W     = $clog2(NUM_SLOTS)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [TIME_BITS-1:0] now,
	input  logic                 update,
	input  logic                 alloc_en,
	input  logic [IDX_W-1:0]     alloc_idx,
	input  logic [TIME_BITS-1:0] alloc_leave,
	output logic [NUM_SLOTS-1:0] free_vec
);

	logic [NUM_SLOTS-1:0] busy_q;
	logic [TIME_BITS-1:0] leave_q [NUM_SLOTS];
	logic [NUM_SLOTS-1:0] busy_kept;
	logic [NUM_SLOTS-1:0] alloc_onehot;

	// A slot stays busy only while its leave time lies after the current arrival.
	always_comb begin
		for (int i = 0; i < NUM_SLOTS; i++) begin
			busy_kept[i]    = busy_q[i] && (leave_q[i] > now);
			alloc_onehot[i] = alloc_en && (alloc_idx == IDX_W'(i));
		end
	end

	assign free_vec = ~busy_kept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= '0;
		end else if (update) begin
			busy_q <= busy_kept | alloc_onehot;
		end
	end

	// Leave times need no reset: an entry is only compared while its slot is busy.
	always_ff @(posedge clk) begin
		if (update && alloc_en) begin
			leave_q[alloc_idx] <= alloc_leave;
		end
	end

endmodule

### sv/tlsa_lowest_free.sv
// Priority encoder of the timed lowest-slot allocator: finds the
// lowest-numbered free slot. Uses no package items.
module tlsa_lowest_free #(
	parameter int unsigned NUM_SLOTS = 32,
	parameter int unsigned IDX_W     = $clog2(NUM_SLOTS)
) (
	input  logic [NUM_SLOTS-1:0] free_vec,
	output logic                 found,
	output logic [IDX_W-1:0]     idx
);

	// Scanning downwards lets the lowest free slot write last.
	always_comb begin
		found = 1'b0;
		idx   = '0;
		for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
			if (free_vec[i]) begin
				found = 1'b1;
				idx   = IDX_W'(i);
			end
		end
	end

endmodule

### sv/timed_lowest_slot_allocator.sv
// Top level of the timed lowest-slot allocator.
// Depends on tlsa_pkg, tlsa_slot_bank and tlsa_lowest_free.
//
//  channel  | direction | tdata (low bit up)            | tuser     | tlast
//  s_axis   | in        | arrival_time, leave_time      | -         | -
//  m_axis   | out       | slot_index, zero pad to 8 bits | full_flag | -
//
// A request is registered on its beat and resolved from the input register:
// the release compares on every slot and the lowest-free encoder run between
// the input register and the result register, so one request is taken each
// cycle unless a held result stalls the pipe, and each result is registered.
// Reset clears the busy flags and both stage valids; stored leave times are
// not reset. A stalled result holds the request register, and s_axis_tready
// falls only while both registers are full and m_axis_tready is low.
module timed_lowest_slot_allocator #(
	parameter int unsigned NUM_SLOTS = 32,
	parameter int unsigned TIME_BITS = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [tlsa_pkg::S_TDATA_W-1:0] s_axis_tdata,  // arrival_time, leave_time
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [tlsa_pkg::M_TDATA_W-1:0] m_axis_tdata,  // slot_index, zero pad
	output logic                           m_axis_tuser   // full_flag
);

	localparam int unsigned IDX_W = $clog2(NUM_SLOTS);

	logic                     req_valid_s1;
	tlsa_pkg::time_field_t    arrival_s1;
	tlsa_pkg::time_field_t    leave_s1;

	logic                     res_valid_s2;
	tlsa_pkg::slot_field_t    slot_s2;
	logic                     full_s2;

	logic                     out_free;
	logic                     fire;
	logic                     in_beat;
	logic [TIME_BITS-1:0]     now;
	logic [TIME_BITS-1:0]     leave;
	logic [NUM_SLOTS-1:0]     free_vec;
	logic                     found;
	logic [IDX_W-1:0]         idx;

	assign out_free      = !res_valid_s2 || m_axis_tready;
	assign fire          = req_valid_s1 && out_free;
	assign s_axis_tready = !req_valid_s1 || out_free;
	assign in_beat       = s_axis_tvalid && s_axis_tready;

	assign now   = TIME_BITS'(arrival_s1);
	assign leave = TIME_BITS'(leave_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			req_valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_beat) begin
			arrival_s1 <= s_axis_tdata[tlsa_pkg::ARRIVAL_LSB +: tlsa_pkg::TIME_FIELD_W];
			leave_s1   <= s_axis_tdata[tlsa_pkg::LEAVE_LSB +: tlsa_pkg::TIME_FIELD_W];
		end
	end

	tlsa_slot_bank #(
		.NUM_SLOTS (NUM_SLOTS),
		.TIME_BITS (TIME_BITS),
		.IDX_W     (IDX_W)
	) u_bank (
		.clk         (clk),
		.arst_n      (arst_n),
		.now         (now),
		.update      (fire),
		.alloc_en    (found),
		.alloc_idx   (idx),
		.alloc_leave (leave),
		.free_vec    (free_vec)
	);

	tlsa_lowest_free #(
		.NUM_SLOTS (NUM_SLOTS),
		.IDX_W     (IDX_W)
	) u_enc (
		.free_vec (free_vec),
		.found    (found),
		.idx      (idx)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s2 <= 1'b0;
		end else if (out_free) begin
			res_valid_s2 <= req_valid_s1;
		end
	end

	// Slot numbers wider than the result field keep only their low bits.
	always_ff @(posedge clk) begin
		if (fire) begin
			slot_s2 <= found ? tlsa_pkg::SLOT_FIELD_W'(idx) : '0;
			full_s2 <= !found;
		end
	end

	assign m_axis_tvalid = res_valid_s2;
	assign m_axis_tdata  = tlsa_pkg::M_TDATA_W'(slot_s2);
	assign m_axis_tuser  = full_s2;

endmodule

### sv/tlsa_checker.sv
// Port-level checker for the timed lowest-slot allocator, bound to the top
// level below. Depends on tlsa_pkg for the result beat width.
module tlsa_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_axis_tvalid,
	input logic                           s_axis_tready,
	input logic                           m_axis_tvalid,
	input logic                           m_axis_tready,
	input logic [tlsa_pkg::M_TDATA_W-1:0] m_axis_tdata,
	input logic                           m_axis_tuser
);

	// The request side stalls only because a result beat is held up.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
		else $error("request side stalled without a blocked result");

	// A full result assigns nothing, so its slot field is zero.
	a_full_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
		else $error("full result carries a non-zero slot");

	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result beat withdrawn while stalled");

	a_data_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result beat changed while stalled");

	// A request accepted into an idle block shows up as a result once it has passed the input and result registers.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && !m_axis_tvalid && s_axis_tready ##1
		!m_axis_tvalid |=> m_axis_tvalid)
		else $error("request beat lost on its way to the result");

endmodule

bind timed_lowest_slot_allocator tlsa_checker u_tlsa_checker (.*);
